[rtl/alr_pkg.sv]
// ----------------------------------------------------------------------------
// alr_pkg
// shared widths and constants for the anti-aliased line rasteriser
// ----------------------------------------------------------------------------
package alr_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 16;
	localparam int IN_W       = COORD_BITS + FRAC_BITS;   // endpoint width
	localparam int PIX_W      = COORD_BITS + 1;           // pixel coordinate width
	localparam int WGT_W      = 9;                        // weight 0..256
	localparam int SLOPE_FRAC = 16;
	localparam int SLOPE_W    = SLOPE_FRAC + 2;           // signed, -1..1

	// gradient divider
	localparam int DIV_DEN_W  = IN_W + 1;                 // major span
	localparam int DIV_NUM_W  = DIV_DEN_W + SLOPE_FRAC + 1;
	localparam int DIV_Q_W    = SLOPE_FRAC + 1;           // quotient <= 1.0
	localparam int DIV_CNT_W  = $clog2(DIV_Q_W + 1);

endpackage

[rtl/alr_div.sv]
// ----------------------------------------------------------------------------
// alr_div
// restoring divider, one quotient bit per cycle, for the line gradient
// ----------------------------------------------------------------------------
module alr_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [alr_pkg::DIV_NUM_W-1:0]   num,
	input  logic [alr_pkg::DIV_DEN_W-1:0]   den,
	output logic                            done,
	output logic [alr_pkg::DIV_Q_W-1:0]     quot
);
	import alr_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   sh_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem2;
	logic [DIV_DEN_W:0]   sub;
	logic                 ge;

	assign rem2 = {rem_q, sh_q[DIV_Q_W-1]};
	assign ge   = rem2 >= {1'b0, den};
	assign sub  = rem2 - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIV_Q_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NUM_W-1:DIV_Q_W];
			sh_q  <= num[DIV_Q_W-1:0];
		end else if (run_q) begin
			rem_q <= ge ? sub[DIV_DEN_W-1:0] : rem2[DIV_DEN_W-1:0];
			sh_q  <= {sh_q[DIV_Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

[rtl/antialiased_line_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_top
// wu anti-aliased line generator, one column pair per advance transfer
// ----------------------------------------------------------------------------
// a new-line transfer (req_type 0) holds the request side through four set-up
// steps, a wait on the bit-serial gradient divider (skipped for a zero major
// span) and five steps per endpoint on one shared 18x10 multiplier; the start
// column is on the result side in the cycle after the last endpoint step. an
// advance transfer (req_type 1) produces its column in the next cycle, so
// advances run at one per cycle while results are taken.
// req_stall is high during the set-up sequence and while a result waits
// stalled.
module antialiased_line_rasterizer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 req_type,
	input  logic signed [alr_pkg::IN_W-1:0]      start_x,
	input  logic signed [alr_pkg::IN_W-1:0]      start_y,
	input  logic signed [alr_pkg::IN_W-1:0]      end_x,
	input  logic signed [alr_pkg::IN_W-1:0]      end_y,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic signed [alr_pkg::PIX_W-1:0]     pixel_x,
	output logic signed [alr_pkg::PIX_W-1:0]     pixel_y,
	output logic [alr_pkg::WGT_W-1:0]            weight_first,
	output logic [alr_pkg::WGT_W-1:0]            weight_second,
	output logic                                 minor_is_x,
	output logic                                 last_column
);
	import alr_pkg::*;

	localparam int COL_W = PIX_W + 1;     // column with headroom for compares
	localparam int YE_W  = IN_W + 10;     // minor coordinate, 16 fraction bits
	localparam int ACC_W = 40;
	localparam int MUL_W = SLOPE_W + 10;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SWAP  = 11'b000_0000_0010,
		ST_ORDER = 11'b000_0000_0100,
		ST_DIFF  = 11'b000_0000_1000,
		ST_DIVS  = 11'b000_0001_0000,
		ST_DIVW  = 11'b000_0010_0000,
		ST_EPA   = 11'b000_0100_0000,
		ST_EPB   = 11'b000_1000_0000,
		ST_EPC   = 11'b001_0000_0000,
		ST_EPD   = 11'b010_0000_0000,
		ST_EPE   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// captured endpoints and the swapped/ordered major (m) and minor (n) axes
	logic signed [IN_W-1:0]      rx0_q, ry0_q, rx1_q, ry1_q;
	logic signed [IN_W-1:0]      m0_q, n0_q, m1_q, n1_q;
	logic [DIV_DEN_W-1:0]        dx_q;
	logic signed [DIV_DEN_W-1:0] dy_q;
	logic                        dneg_q;

	// line state
	logic                        busy_q;
	logic                        phase2_q;     // 0: end column pending, 1: interior
	logic                        steep_q;
	logic signed [SLOPE_W-1:0]   slope_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [COL_W-1:0]     col_now_q, col_end_q;
	logic [PIX_W-1:0]            ep_minor_q;
	logic [WGT_W-1:0]            ep_w1_q, ep_w2_q;

	// endpoint sequence working registers
	logic                        sel_q;        // 0: start endpoint, 1: end endpoint
	logic signed [COL_W-1:0]     col_q;
	logic [WGT_W-1:0]            gap_q;
	logic signed [MUL_W-1:0]     prod_q;
	logic signed [YE_W-1:0]      ye_q;
	logic [WGT_W-1:0]            w1_q;
	logic signed [COL_W-1:0]     sc_col_q;
	logic [PIX_W-1:0]            sc_minor_q;
	logic [WGT_W-1:0]            sc_w1_q, sc_w2_q;

	// result register
	logic                        res_valid_q;
	logic [PIX_W-1:0]            px_q, py_q;
	logic [WGT_W-1:0]            wf_q, ws_q;
	logic                        mx_q, last_q;

	logic in_xfer, res_xfer, new_line, advance;

	assign req_stall = (state_q != ST_IDLE) || (res_valid_q && res_stall);
	assign in_xfer   = req_valid && !req_stall;
	assign res_xfer  = res_valid_q && !res_stall;
	assign new_line  = in_xfer && !req_type;
	assign advance   = in_xfer && req_type && busy_q;

	// ---- set-up arithmetic ----
	logic signed [DIV_DEN_W-1:0] ddx, ddy;
	logic [DIV_DEN_W-1:0]        adx, ady, abs_dy;
	assign ddx    = {rx1_q[IN_W-1], rx1_q} - {rx0_q[IN_W-1], rx0_q};
	assign ddy    = {ry1_q[IN_W-1], ry1_q} - {ry0_q[IN_W-1], ry0_q};
	assign adx    = ddx[DIV_DEN_W-1] ? DIV_DEN_W'(-ddx) : DIV_DEN_W'(ddx);
	assign ady    = ddy[DIV_DEN_W-1] ? DIV_DEN_W'(-ddy) : DIV_DEN_W'(ddy);
	assign abs_dy = dy_q[DIV_DEN_W-1] ? DIV_DEN_W'(-dy_q) : DIV_DEN_W'(dy_q);

	// gradient divider, dividend taken straight from the span registers
	logic                div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_Q_W-1:0]  div_quot;
	assign div_start = (state_q == ST_DIVS) && (dx_q != '0);
	assign div_num   = DIV_NUM_W'({abs_dy, {SLOPE_FRAC{1'b0}}}) + DIV_NUM_W'(dx_q >> 1);

	alr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (dx_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ---- endpoint arithmetic ----
	logic signed [IN_W-1:0]  ep_m, ep_n;
	logic signed [IN_W:0]    mh, mneg;
	logic signed [COL_W-1:0] col_pos, col_neg;
	logic signed [IN_W+1:0]  diff;
	logic signed [MUL_W-1:0] prod_neg;
	logic [MUL_W-1:0]        rnd_mag;
	logic signed [YE_W-1:0]  rnd_ye;
	logic [SLOPE_FRAC-1:0]   frac_e;
	logic [SLOPE_FRAC:0]     rfrac_e;
	logic [MUL_W-1:0]        wsum;

	assign ep_m    = sel_q ? m1_q : m0_q;
	assign ep_n    = sel_q ? n1_q : n0_q;
	assign mh      = {ep_m[IN_W-1], ep_m} + (IN_W+1)'(128);
	assign mneg    = (IN_W+1)'(128) - {ep_m[IN_W-1], ep_m};
	assign col_pos = COL_W'(mh >>> FRAC_BITS);
	assign col_neg = -COL_W'(mneg >>> FRAC_BITS);
	assign diff    = {col_q, {FRAC_BITS{1'b0}}} - {{2{ep_m[IN_W-1]}}, ep_m};
	assign prod_neg = -prod_q;
	assign rnd_mag  = prod_q[MUL_W-1] ? (MUL_W'(prod_neg + MUL_W'(128)) >> FRAC_BITS)
	                                  : (MUL_W'(prod_q + MUL_W'(128)) >> FRAC_BITS);
	assign rnd_ye   = prod_q[MUL_W-1] ? -YE_W'(rnd_mag) : YE_W'(rnd_mag);
	assign frac_e   = ye_q[SLOPE_FRAC-1:0];
	assign rfrac_e  = (SLOPE_FRAC+1)'(1 << SLOPE_FRAC) - {1'b0, frac_e};

	// shared multiplier
	logic signed [SLOPE_W-1:0] mul_a;
	logic signed [9:0]         mul_b;
	logic signed [MUL_W-1:0]   mul_p;
	always_comb begin
		case (state_q)
			ST_EPB: begin
				mul_a = slope_q;
				mul_b = diff[9:0];
			end
			ST_EPD: begin
				mul_a = SLOPE_W'({1'b0, rfrac_e});
				mul_b = {1'b0, gap_q};
			end
			ST_EPE: begin
				mul_a = SLOPE_W'({1'b0, frac_e});
				mul_b = {1'b0, gap_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;
	assign wsum  = MUL_W'(mul_p) + MUL_W'(1 << (SLOPE_FRAC - 1));

	// ---- interior column ----
	logic [SLOPE_FRAC-1:0]   frac_i;
	logic [SLOPE_FRAC:0]     rfrac_i;
	logic [SLOPE_FRAC:0]     wi1_sum, wi2_sum;
	logic signed [COL_W-1:0] col_next;
	assign frac_i   = acc_q[SLOPE_FRAC-1:0];
	assign rfrac_i  = (SLOPE_FRAC+1)'(1 << SLOPE_FRAC) - {1'b0, frac_i};
	assign wi1_sum  = rfrac_i + (SLOPE_FRAC+1)'(128);
	assign wi2_sum  = {1'b0, frac_i} + (SLOPE_FRAC+1)'(128);
	assign col_next = col_now_q + COL_W'(1);

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			phase2_q <= 1'b0;
			sel_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (new_line) begin
						busy_q  <= 1'b0;
						state_q <= ST_SWAP;
					end else if (advance) begin
						if (!phase2_q) begin
							if (col_now_q >= col_end_q)
								busy_q <= 1'b0;
							else
								phase2_q <= 1'b1;
						end else if (col_next >= col_end_q) begin
							busy_q   <= 1'b0;
							phase2_q <= 1'b0;
						end
					end
				end
				ST_SWAP:  state_q <= ST_ORDER;
				ST_ORDER: state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_DIVS;
				ST_DIVS: begin
					sel_q   <= 1'b0;
					state_q <= (dx_q == '0) ? ST_EPA : ST_DIVW;
				end
				ST_DIVW:  if (div_done) state_q <= ST_EPA;
				ST_EPA:   state_q <= ST_EPB;
				ST_EPB:   state_q <= ST_EPC;
				ST_EPC:   state_q <= ST_EPD;
				ST_EPD:   state_q <= ST_EPE;
				ST_EPE: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_EPA;
					end else begin
						busy_q   <= 1'b1;
						phase2_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (new_line) begin
					rx0_q <= start_x;
					ry0_q <= start_y;
					rx1_q <= end_x;
					ry1_q <= end_y;
				end else if (advance && phase2_q) begin
					col_now_q <= col_next;
					acc_q     <= acc_q + ACC_W'(slope_q);
				end
			end
			ST_SWAP: begin
				steep_q <= ady > adx;
				if (ady > adx) begin
					m0_q <= ry0_q; n0_q <= rx0_q;
					m1_q <= ry1_q; n1_q <= rx1_q;
				end else begin
					m0_q <= rx0_q; n0_q <= ry0_q;
					m1_q <= rx1_q; n1_q <= ry1_q;
				end
			end
			ST_ORDER: begin
				if (m0_q > m1_q) begin
					m0_q <= m1_q; n0_q <= n1_q;
					m1_q <= m0_q; n1_q <= n0_q;
				end
			end
			ST_DIFF: begin
				dx_q <= DIV_DEN_W'({m1_q[IN_W-1], m1_q} - {m0_q[IN_W-1], m0_q});
				dy_q <= {n1_q[IN_W-1], n1_q} - {n0_q[IN_W-1], n0_q};
			end
			ST_DIVS: begin
				dneg_q <= dy_q[DIV_DEN_W-1];
				if (dx_q == '0)
					slope_q <= SLOPE_W'(1 << SLOPE_FRAC);
			end
			ST_DIVW: begin
				if (div_done)
					slope_q <= dneg_q ? -SLOPE_W'(div_quot) : SLOPE_W'(div_quot);
			end
			ST_EPA: begin
				col_q <= ep_m[IN_W-1] ? col_neg : col_pos;
				gap_q <= WGT_W'(256) - WGT_W'(mh[FRAC_BITS-1:0]);
			end
			ST_EPB: prod_q <= mul_p;
			ST_EPC: ye_q <= {{(YE_W-IN_W-FRAC_BITS){ep_n[IN_W-1]}}, ep_n, {FRAC_BITS{1'b0}}}
			              + rnd_ye;
			ST_EPD: w1_q <= wsum[SLOPE_FRAC+WGT_W-1:SLOPE_FRAC];
			ST_EPE: begin
				if (!sel_q) begin
					sc_col_q   <= col_q;
					sc_minor_q <= ye_q[SLOPE_FRAC+PIX_W-1:SLOPE_FRAC];
					sc_w1_q    <= w1_q;
					sc_w2_q    <= wsum[SLOPE_FRAC+WGT_W-1:SLOPE_FRAC];
					acc_q      <= ACC_W'(ye_q) + ACC_W'(slope_q);
					col_now_q  <= col_q + COL_W'(1);
				end else begin
					col_end_q  <= col_q;
					ep_minor_q <= ye_q[SLOPE_FRAC+PIX_W-1:SLOPE_FRAC];
					ep_w1_q    <= w1_q;
					ep_w2_q    <= wsum[SLOPE_FRAC+WGT_W-1:SLOPE_FRAC];
				end
			end
			default: ;
		endcase
	end

	// ---- result register ----
	logic               load;
	logic [PIX_W-1:0]   e_col, e_minor;
	logic [WGT_W-1:0]   e_w1, e_w2;
	logic               e_last;

	always_comb begin
		load    = 1'b0;
		e_col   = PIX_W'(sc_col_q);
		e_minor = sc_minor_q;
		e_w1    = sc_w1_q;
		e_w2    = sc_w2_q;
		e_last  = 1'b0;
		if (state_q == ST_EPE && sel_q) begin
			load = 1'b1;
		end else if (advance && !phase2_q) begin
			load    = 1'b1;
			e_col   = PIX_W'(col_end_q);
			e_minor = ep_minor_q;
			e_w1    = ep_w1_q;
			e_w2    = ep_w2_q;
			e_last  = col_now_q >= col_end_q;
		end else if (advance) begin
			load    = 1'b1;
			e_col   = PIX_W'(col_now_q);
			e_minor = acc_q[SLOPE_FRAC+PIX_W-1:SLOPE_FRAC];
			e_w1    = wi1_sum[SLOPE_FRAC:FRAC_BITS];
			e_w2    = wi2_sum[SLOPE_FRAC:FRAC_BITS];
			e_last  = col_next >= col_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load)
			res_valid_q <= 1'b1;
		else if (res_xfer)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= steep_q ? e_minor : e_col;
			py_q   <= steep_q ? e_col : e_minor;
			wf_q   <= e_w1;
			ws_q   <= e_w2;
			mx_q   <= steep_q;
			last_q <= e_last;
		end
	end

	assign res_valid     = res_valid_q;
	assign pixel_x       = px_q;
	assign pixel_y       = py_q;
	assign weight_first  = wf_q;
	assign weight_second = ws_q;
	assign minor_is_x    = mx_q;
	assign last_column   = last_q;

endmodule

[rtl/alr_chk.sv]
// ----------------------------------------------------------------------------
// alr_chk
// port-level checks for the line rasteriser
// ----------------------------------------------------------------------------
module alr_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_stall,
	input logic                              req_type,
	input logic                              res_valid,
	input logic                              res_stall,
	input logic signed [alr_pkg::PIX_W-1:0]  pixel_x,
	input logic signed [alr_pkg::PIX_W-1:0]  pixel_y,
	input logic [alr_pkg::WGT_W-1:0]         weight_first,
	input logic [alr_pkg::WGT_W-1:0]         weight_second
);
	import alr_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(pixel_x) && $stable(pixel_y))
		else $error("stalled result changed");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> weight_first <= WGT_W'(256) && weight_second <= WGT_W'(256))
		else $error("weight above full coverage");

	a_setup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !req_type |=> req_stall)
		else $error("new line transfer not followed by set-up");

	a_setup_empty: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && !req_type |=> !res_valid)
		else $error("result present during set-up");

endmodule

bind antialiased_line_rasterizer_top alr_chk u_alr_chk (.*);
